FILE: hw/rtl/minmax_image_normaliser_top_assert.svh
// Assertion macros used by the checker file of the block.
`ifndef MINMAX_IMAGE_NORMALISER_TOP_ASSERT_SVH
`define MINMAX_IMAGE_NORMALISER_TOP_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MMN_ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MMN_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/mmn_pkg.sv
`default_nettype none

package mmn_pkg;

    localparam int MAX_PIXELS_DEF = 4096;

    localparam int SAMPLE_W = 32;
    localparam int NORM_W   = 16;
    localparam int PIX_W    = 8;
    localparam int CH_NUM   = 3;

    // The quotient of the stretch always fits in the output width.
    localparam int QUO_W   = PIX_W;
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int REM_W   = SAMPLE_W + NORM_W;
    // Divisor is range * 256, pre-shifted by the top quotient bit.
    localparam int DIV_LSH = 8 + QUO_W - 1;
    localparam int DIV_W   = SAMPLE_W + DIV_LSH;

    localparam logic [NORM_W-1:0] NORM_RESET = 16'd65024;
    localparam logic [PIX_W-1:0]  PIX_ONE    = 8'd1;
    localparam logic [PIX_W-1:0]  PIX_MAX    = 8'd255;
    localparam logic [QUO_W-1:0]  QUO_SAT    = 8'd254;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } mmn_state_t;

    typedef struct packed {
        logic fetch;
        logic mul;
        logic step;
    } mmn_lane_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mmn_ram.sv
`default_nettype none

module mmn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mmn_stretch_lane.sv
`default_nettype none

module mmn_stretch_lane (
    input  wire logic                          clk,
    input  wire mmn_pkg::mmn_lane_ctl_t        ctl,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  sample_min,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  sample_range,
    input  wire logic [mmn_pkg::NORM_W-1:0]    norm,
    input  wire logic [mmn_pkg::DIV_W-1:0]     divisor,
    output logic      [mmn_pkg::QUO_W-1:0]     quotient
);

    logic [mmn_pkg::SAMPLE_W-1:0] diff_reg;
    logic [mmn_pkg::SAMPLE_W-1:0] diff_next;
    logic [mmn_pkg::REM_W-1:0]    rem_reg;
    logic [mmn_pkg::REM_W-1:0]    product;
    logic [mmn_pkg::REM_W-1:0]    divisor_ext;
    logic [mmn_pkg::QUO_W-1:0]    quo_reg;
    logic                         ge;

    always_comb
    begin
        if (sample >= sample_min)
        begin
            diff_next = sample - sample_min;
        end
        else
        begin
            diff_next = '0;
        end
        if (diff_next > sample_range)
        begin
            diff_next = sample_range;
        end
    end

    assign product     = mmn_pkg::REM_W'(diff_reg) * mmn_pkg::REM_W'(norm);
    assign divisor_ext = mmn_pkg::REM_W'(divisor);
    assign ge          = (rem_reg >= divisor_ext);

    // Restoring division, one quotient bit per step, most significant first.
    always_ff @(posedge clk)
    begin
        if (ctl.fetch)
        begin
            diff_reg <= diff_next;
        end
        if (ctl.mul)
        begin
            rem_reg <= product;
            quo_reg <= '0;
        end
        else if (ctl.step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - divisor_ext;
            end
            quo_reg <= {quo_reg[mmn_pkg::QUO_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/minmax_image_normaliser_top.sv
// Min-max contrast stretch over a stored image of three-channel 16.16 pixels.
// Input channel: pixel_valid / pixel_stall with command, first_pixel and the
// three samples. A load (command 0) is stored when accepted, so loads stream
// at one pixel per cycle outside a read-out. A read-out (command 1) returns
// the next stored pixel as 8-bit channels on the result channel
// (result_valid / result_stall), with last_out marking the final stored pixel.
// A read-out stalls the input until it is done, so no new item is taken
// before then. It passes through one pixel memory read, one subtract and one
// multiply stage, and an 8-step restoring divider in each of the three
// channel lanes, with one divisor shift register shared by the lanes.
// A read-out on an empty store gives no result and frees the input at once.
// The result sits in an output register; while the receiver stalls it, the
// block still takes loads, and a further read-out waits at its final stage
// until the register is taken.
// norm_scaled is written on its own valid/ready channel, always ready, and
// must only be written while the block is idle.
// Reset clears the pixel count, read pointer, extremes and output valid, and
// restores norm_scaled to 254.0; the pixel memory needs no clearing pass.
`default_nettype none

module minmax_image_normaliser_top #(
    parameter int MAX_PIXELS = mmn_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          pixel_valid,
    output logic                               pixel_stall,
    input  wire logic                          command,
    input  wire logic                          first_pixel,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  red_in,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  green_in,
    input  wire logic [mmn_pkg::SAMPLE_W-1:0]  blue_in,

    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [mmn_pkg::PIX_W-1:0]     red_out,
    output logic      [mmn_pkg::PIX_W-1:0]     green_out,
    output logic      [mmn_pkg::PIX_W-1:0]     blue_out,
    output logic                               last_out,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [mmn_pkg::NORM_W-1:0]    norm_scaled
);

    localparam int AW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW    = $clog2(MAX_PIXELS + 1);
    localparam int SW    = mmn_pkg::SAMPLE_W;
    localparam int PIX_B = mmn_pkg::CH_NUM * SW;

    mmn_pkg::mmn_state_t state_reg, state_next;

    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              rp_reg, rp_next;
    logic [SW-1:0]              min_reg, min_next;
    logic [SW-1:0]              max_reg, max_next;
    logic [mmn_pkg::NORM_W-1:0] norm_reg;
    logic                       last_reg, last_next;
    logic [mmn_pkg::STEP_W-1:0] step_reg;
    logic [mmn_pkg::DIV_W-1:0]  dshift_reg;

    logic                       out_valid_reg;
    logic [mmn_pkg::PIX_W-1:0]  red_reg, green_reg, blue_reg;
    logic                       out_last_reg;

    logic                       accept;
    logic                       load_acc;
    logic                       read_acc;
    logic                       out_free;
    logic                       out_load;
    logic                       div_done;
    mmn_pkg::mmn_lane_ctl_t     lane_ctl;

    logic [CW-1:0]              count_base;
    logic [CW-1:0]              rp_base;
    logic [CW-1:0]              rd_ptr;
    logic [CW-1:0]              rd_ptr_inc;
    logic                       store_room;
    logic [SW-1:0]              pix_lo, pix_hi;
    logic [SW-1:0]              sample_range;

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [PIX_B-1:0]           ram_wdata, ram_rdata;

    logic [mmn_pkg::QUO_W-1:0]  quo_r, quo_g, quo_b;

    assign accept   = pixel_valid && !pixel_stall;
    assign load_acc = accept && (command == mmn_pkg::CMD_LOAD);
    assign read_acc = accept && (command == mmn_pkg::CMD_READ);
    assign out_free = !out_valid_reg || !result_stall;
    assign div_done = (step_reg == mmn_pkg::STEP_W'(mmn_pkg::QUO_W - 1));
    assign sample_range = max_reg - min_reg;

    // Load path: new-image handling, capacity check and extremes of the pixel.
    always_comb
    begin
        count_base = first_pixel ? '0 : count_reg;
        store_room = (count_base < CW'(MAX_PIXELS));
        pix_lo = red_in;
        pix_hi = red_in;
        if (green_in < pix_lo) pix_lo = green_in;
        if (green_in > pix_hi) pix_hi = green_in;
        if (blue_in < pix_lo)  pix_lo = blue_in;
        if (blue_in > pix_hi)  pix_hi = blue_in;
    end

    // Read-out path: pointer restart and wrap.
    always_comb
    begin
        rp_base = first_pixel ? '0 : rp_reg;
        rd_ptr  = (rp_base >= count_reg) ? '0 : rp_base;
        rd_ptr_inc = rd_ptr + CW'(1);
    end

    always_comb
    begin
        count_next = count_reg;
        rp_next    = rp_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        last_next  = last_reg;
        if (load_acc)
        begin
            rp_next    = first_pixel ? '0 : rp_reg;
            count_next = count_base;
            if (store_room)
            begin
                count_next = count_base + CW'(1);
                if (count_base == '0)
                begin
                    min_next = pix_lo;
                    max_next = pix_hi;
                end
                else
                begin
                    if (pix_lo < min_reg) min_next = pix_lo;
                    if (pix_hi > max_reg) max_next = pix_hi;
                end
            end
        end
        else if (read_acc)
        begin
            if (count_reg == '0)
            begin
                rp_next = rp_base;
            end
            else
            begin
                last_next = (rd_ptr_inc == count_reg);
                rp_next   = (rd_ptr_inc == count_reg) ? '0 : rd_ptr_inc;
            end
        end
    end

    assign ram_we    = load_acc && store_room;
    assign ram_waddr = count_base[AW-1:0];
    assign ram_wdata = {blue_in, green_in, red_in};
    assign ram_raddr = rd_ptr[AW-1:0];

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmn_pkg::ST_IDLE:
            begin
                if (read_acc && (count_reg != '0))
                begin
                    state_next = mmn_pkg::ST_FETCH;
                end
            end
            mmn_pkg::ST_FETCH: state_next = mmn_pkg::ST_MUL;
            mmn_pkg::ST_MUL:   state_next = mmn_pkg::ST_DIV;
            mmn_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = mmn_pkg::ST_OUT;
                end
            end
            mmn_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = mmn_pkg::ST_IDLE;
                end
            end
            default: state_next = mmn_pkg::ST_IDLE;
        endcase
    end

    // Output decode. In idle the input is never stalled, so a read-out
    // transaction is taken whenever it is offered.
    always_comb
    begin
        pixel_stall    = 1'b1;
        ram_re         = 1'b0;
        lane_ctl.fetch = 1'b0;
        lane_ctl.mul   = 1'b0;
        lane_ctl.step  = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            mmn_pkg::ST_IDLE:
            begin
                pixel_stall = 1'b0;
                ram_re      = pixel_valid && (command == mmn_pkg::CMD_READ) &&
                              (count_reg != '0);
            end
            mmn_pkg::ST_FETCH: lane_ctl.fetch = 1'b1;
            mmn_pkg::ST_MUL:   lane_ctl.mul   = 1'b1;
            mmn_pkg::ST_DIV:   lane_ctl.step  = 1'b1;
            mmn_pkg::ST_OUT:   out_load       = out_free;
            default: pixel_stall = 1'b1;
        endcase
    end

    function automatic logic [mmn_pkg::PIX_W-1:0] finish(
        input logic [mmn_pkg::QUO_W-1:0] q,
        input logic                      flat
    );
        logic [mmn_pkg::PIX_W-1:0] r;
        if (flat)
        begin
            r = mmn_pkg::PIX_ONE;
        end
        else if (q >= mmn_pkg::QUO_SAT)
        begin
            r = mmn_pkg::PIX_MAX;
        end
        else
        begin
            r = q + mmn_pkg::PIX_ONE;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmn_pkg::ST_IDLE;
            count_reg     <= '0;
            rp_reg        <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            norm_reg      <= mmn_pkg::NORM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rp_reg    <= rp_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            if (cfg_valid && cfg_ready)
            begin
                norm_reg <= norm_scaled;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        if (lane_ctl.mul)
        begin
            step_reg   <= '0;
            dshift_reg <= {sample_range, mmn_pkg::DIV_LSH'(0)};
        end
        else if (lane_ctl.step)
        begin
            step_reg   <= step_reg + mmn_pkg::STEP_W'(1);
            dshift_reg <= dshift_reg >> 1;
        end
        if (out_load)
        begin
            red_reg      <= finish(quo_r, sample_range == '0);
            green_reg    <= finish(quo_g, sample_range == '0);
            blue_reg     <= finish(quo_b, sample_range == '0);
            out_last_reg <= last_reg;
        end
    end

    mmn_ram #(
        .WIDTH (PIX_B),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    mmn_stretch_lane u_lane_r (
        .clk          (clk),
        .ctl          (lane_ctl),
        .sample       (ram_rdata[SW-1:0]),
        .sample_min   (min_reg),
        .sample_range (sample_range),
        .norm         (norm_reg),
        .divisor      (dshift_reg),
        .quotient     (quo_r)
    );

    mmn_stretch_lane u_lane_g (
        .clk          (clk),
        .ctl          (lane_ctl),
        .sample       (ram_rdata[2*SW-1:SW]),
        .sample_min   (min_reg),
        .sample_range (sample_range),
        .norm         (norm_reg),
        .divisor      (dshift_reg),
        .quotient     (quo_g)
    );

    mmn_stretch_lane u_lane_b (
        .clk          (clk),
        .ctl          (lane_ctl),
        .sample       (ram_rdata[3*SW-1:2*SW]),
        .sample_min   (min_reg),
        .sample_range (sample_range),
        .norm         (norm_reg),
        .divisor      (dshift_reg),
        .quotient     (quo_b)
    );

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign red_out      = red_reg;
    assign green_out    = green_reg;
    assign blue_out     = blue_reg;
    assign last_out     = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mmn_checker.sv
`default_nettype none

`include "minmax_image_normaliser_top_assert.svh"

module mmn_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          pixel_valid,
    input wire logic                          pixel_stall,
    input wire logic                          command,
    input wire logic                          result_valid,
    input wire logic                          result_stall,
    input wire logic [mmn_pkg::PIX_W-1:0]     red_out,
    input wire logic [mmn_pkg::PIX_W-1:0]     green_out,
    input wire logic [mmn_pkg::PIX_W-1:0]     blue_out,
    input wire logic                          last_out
);

    // A stalled result keeps its payload.
    `MMN_ASSERT_CLK(a_result_hold, result_valid && result_stall |=> result_valid && $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(last_out), "stalled result changed")

    // The stretch adds one, so no channel of a result is ever zero.
    `MMN_ASSERT_CLK(a_result_nonzero, result_valid |-> red_out != 0 && green_out != 0 && blue_out != 0, "result channel is zero")

    // A load transaction taken with no result pending never creates one.
    `MMN_ASSERT_CLK(a_load_no_result, pixel_valid && !pixel_stall && command == mmn_pkg::CMD_LOAD && !result_valid |=> !result_valid, "load produced a result")

    // Reset leaves no result on the output.
    `MMN_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !result_valid, "result valid after reset")

endmodule

bind minmax_image_normaliser_top mmn_checker u_mmn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .command      (command),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .last_out     (last_out)
);

`default_nettype wire
